FILE: hdl/lft_pkg.sv
// ----------------------------------------------------------------------------
// Log line field tokenizer package
// Shared constants, codes, record types and delimiter helpers.
// ----------------------------------------------------------------------------
package lft_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    // Characters the tokenizer reacts to.
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Delimiter codes shared by the nesting and strip stacks.
    localparam logic [2:0] CODE_LBRACK = 3'd0;
    localparam logic [2:0] CODE_RBRACK = 3'd1;
    localparam logic [2:0] CODE_LBRACE = 3'd2;
    localparam logic [2:0] CODE_RBRACE = 3'd3;
    localparam logic [2:0] CODE_DQUOTE = 3'd4;
    localparam logic [2:0] CODE_SQUOTE = 3'd5;
    localparam logic [2:0] CODE_NONE   = 3'd6;

    // Result kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Result slots of one input step, in delivery order.
    localparam int SLOT_PREV  = 0;
    localparam int SLOT_FINAL = 1;
    localparam int SLOT_END   = 2;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [2:0] code;
    } lft_stk_cmd_t;

    typedef struct packed {
        logic       has;
        logic [2:0] top;
        logic       overflow;
    } lft_stk_stat_t;

    // Up to three results caused by one input byte.
    typedef struct packed {
        logic [2:0] slot_v;
        logic [7:0] ch_prev;
        logic [7:0] ch_final;
        logic       line_done;
        logic       overflow;
    } lft_rec_t;

    function automatic logic [2:0] delim_code(input logic [7:0] c);
        logic [2:0] r;
        unique case (c)
            CH_LBRACK: r = CODE_LBRACK;
            CH_RBRACK: r = CODE_RBRACK;
            CH_LBRACE: r = CODE_LBRACE;
            CH_RBRACE: r = CODE_RBRACE;
            CH_DQUOTE: r = CODE_DQUOTE;
            CH_SQUOTE: r = CODE_SQUOTE;
            default:   r = CODE_NONE;
        endcase
        return r;
    endfunction

    function automatic logic closes(input logic [2:0] top, input logic [7:0] c);
        return (top == CODE_LBRACK && c == CH_RBRACK) ||
               (top == CODE_LBRACE && c == CH_RBRACE) ||
               (top == CODE_DQUOTE && c == CH_DQUOTE) ||
               (top == CODE_SQUOTE && c == CH_SQUOTE);
    endfunction

endpackage

FILE: hdl/lft_stack.sv
// ----------------------------------------------------------------------------
// Delimiter stack
// Saturating stack with the top held in a register and the entry below it
// prefetched from the memory every cycle, so a pop needs no memory read.
// ----------------------------------------------------------------------------
module lft_stack #(
    parameter int DEPTH = lft_pkg::STACK_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lft_pkg::lft_stk_cmd_t cmd,
    output lft_pkg::lft_stk_stat_t stat
);
    import lft_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [2:0]    mem [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] below_idx;
    logic [2:0]    top_reg;
    logic [2:0]    below_reg;
    logic          full;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign do_push   = cmd.push && !full;
    assign do_pop    = cmd.pop && (count_reg != '0);
    assign below_idx = count_next - CW'(2);

    always_comb begin
        priority if (cmd.clear) begin
            count_next = '0;
        end else if (do_push) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop) begin
            count_next = count_reg - CW'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // The read address tracks the entry under the next top, so the
    // registered data is the new top whenever the following beat pops.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[count_reg[AW-1:0]] <= cmd.code;
        end
        below_reg <= mem[below_idx[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            top_reg <= cmd.code;
        end else if (do_pop) begin
            top_reg <= below_reg;
        end
    end

    assign stat.has      = (count_reg != '0);
    assign stat.top      = top_reg;
    assign stat.overflow = cmd.push && full;

endmodule

FILE: hdl/lft_front.sv
// ----------------------------------------------------------------------------
// Tokenizer front end
// Classifies each byte, keeps the token state and both stacks, and forms the
// record of results that the byte causes.
// ----------------------------------------------------------------------------
module lft_front #(
    parameter int STACK_DEPTH = lft_pkg::STACK_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        char_in,
    input  logic              line_last,
    output logic              rec_push,
    output lft_pkg::lft_rec_t rec
);
    import lft_pkg::*;

    logic [7:0] held_byte_reg;
    logic       held_valid_reg;
    logic       at_start_reg;
    logic       after_space_reg;
    logic       ovf_reg;

    lft_stk_cmd_t  nest_cmd;
    lft_stk_cmd_t  strip_cmd;
    lft_stk_stat_t nest_stat;
    lft_stk_stat_t strip_stat;

    logic [7:0] c;
    logic [2:0] code;
    logic       is_space;
    logic       collapsed;
    logic       is_quote;
    logic       nest_hit;
    logic       tok;
    logic       split;
    logic       strip_push;
    logic       take;
    logic [7:0] held_mid;
    logic       held_mid_v;
    logic       start_mid;
    logic       drop;
    logic       ovf_now;

    always_comb begin
        c         = (char_in == CH_TAB) ? CH_SPACE : char_in;
        is_space  = (c == CH_SPACE);
        collapsed = is_space && after_space_reg;
        code      = delim_code(c);
        is_quote  = (code == CODE_DQUOTE) || (code == CODE_SQUOTE);
        nest_hit  = nest_stat.has && (nest_stat.top == code);

        // A space outside nesting ends the token; collapsed spaces only act when they end the line.
        tok   = !collapsed && !(is_space && !nest_stat.has);
        split = line_last || (!collapsed && is_space && !nest_stat.has);

        // Delimiters before the first kept byte go onto the strip stack.
        strip_push = tok && !held_valid_reg && (code != CODE_NONE);
        take       = tok && !strip_push;
        held_mid   = take ? c : held_byte_reg;
        held_mid_v = take || held_valid_reg;
        start_mid  = tok ? 1'b0 : at_start_reg;
        drop       = split && held_mid_v && strip_stat.has &&
                     closes(strip_stat.top, held_mid);

        nest_cmd.code  = code;
        nest_cmd.clear = accept && line_last;
        nest_cmd.push  = accept && !collapsed &&
                         ((code == CODE_LBRACK) || (code == CODE_LBRACE) ||
                          (is_quote && !nest_hit));
        nest_cmd.pop   = accept && !collapsed && nest_stat.has &&
                         ((is_quote && nest_hit) ||
                          (code == CODE_RBRACK && nest_stat.top == CODE_LBRACK) ||
                          (code == CODE_RBRACE && nest_stat.top == CODE_LBRACE));

        strip_cmd.code  = code;
        strip_cmd.clear = accept && line_last;
        strip_cmd.push  = accept && strip_push;
        strip_cmd.pop   = accept && drop;

        ovf_now = ovf_reg || nest_stat.overflow || strip_stat.overflow;

        rec.slot_v[SLOT_PREV]  = take && held_valid_reg;
        rec.slot_v[SLOT_FINAL] = split && held_mid_v && !drop;
        rec.slot_v[SLOT_END]   = split && (!start_mid || line_last);
        rec.ch_prev            = held_byte_reg;
        rec.ch_final           = held_mid;
        rec.line_done          = line_last;
        rec.overflow           = ovf_now;

        rec_push = accept && (rec.slot_v != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_byte_reg   <= '0;
            held_valid_reg  <= 1'b0;
            at_start_reg    <= 1'b1;
            after_space_reg <= 1'b1;
            ovf_reg         <= 1'b0;
        end else if (accept) begin
            held_byte_reg   <= held_mid;
            held_valid_reg  <= split ? 1'b0 : held_mid_v;
            at_start_reg    <= split ? 1'b1 : start_mid;
            after_space_reg <= line_last ? 1'b1 : (collapsed ? after_space_reg : is_space);
            ovf_reg         <= line_last ? 1'b0 : ovf_now;
        end
    end

    lft_stack #(.DEPTH(STACK_DEPTH)) u_nest (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (nest_cmd),
        .stat    (nest_stat)
    );

    lft_stack #(.DEPTH(STACK_DEPTH)) u_strip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (strip_cmd),
        .stat    (strip_stat)
    );

endmodule

FILE: hdl/lft_queue.sv
// ----------------------------------------------------------------------------
// Record queue
// Short FIFO of result records between the front end and the back end.
// ----------------------------------------------------------------------------
module lft_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lft_pkg::lft_rec_t push_rec,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output lft_pkg::lft_rec_t head
);
    import lft_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    lft_rec_t      entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_pop;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

FILE: hdl/lft_back.sv
// ----------------------------------------------------------------------------
// Tokenizer back end
// Walks the valid slots of the head record and delivers one result beat per
// cycle through the output register, while a record waits and m_ready is high.
// ----------------------------------------------------------------------------
module lft_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  lft_pkg::lft_rec_t head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_item_kind,
    output logic [7:0]        m_char_out,
    output logic              m_line_done,
    output logic              m_stack_overflow,
    output logic              m_run_last
);
    import lft_pkg::*;

    logic [2:0] sent_reg;
    logic [2:0] remaining;
    logic [2:0] sel;
    logic       last_one;
    logic       load;
    logic       m_valid_reg;
    logic       kind_reg;
    logic [7:0] char_reg;
    logic       done_reg;
    logic       ovf_reg;
    logic       run_last_reg;

    always_comb begin
        remaining = head.slot_v & ~sent_reg;
        priority if (remaining[SLOT_PREV]) begin
            sel = 3'b001;
        end else if (remaining[SLOT_FINAL]) begin
            sel = 3'b010;
        end else begin
            sel = 3'b100;
        end
        last_one = ((remaining & ~sel) == '0);
        load     = head_valid && (!m_valid_reg || m_ready);
        pop      = load && last_one;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sent_reg    <= '0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
            sent_reg    <= last_one ? 3'b000 : (sent_reg | sel);
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg     <= sel[SLOT_END] ? KIND_END : KIND_BYTE;
            char_reg     <= sel[SLOT_PREV] ? head.ch_prev :
                            (sel[SLOT_FINAL] ? head.ch_final : 8'h00);
            done_reg     <= sel[SLOT_END] && head.line_done;
            ovf_reg      <= head.overflow;
            run_last_reg <= last_one;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_item_kind      = kind_reg;
    assign m_char_out       = char_reg;
    assign m_line_done      = done_reg;
    assign m_stack_overflow = ovf_reg;
    assign m_run_last       = run_last_reg;

endmodule

FILE: hdl/log_line_field_tokenizer_top.sv
// Path: a byte's result record is written into the queue as the byte is accepted,
// and the queue head is then loaded into the output register beat by beat.
// Throughput: one byte per cycle while the queue has room; a byte that causes
// several results holds the back end while its output register sends them one by one.
// Reset: synchronous, active low; clears counts, flags and valid bits. Stack
// entries are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Log line field tokenizer
// Splits a byte stream of log lines into quote and bracket aware tokens.
// ----------------------------------------------------------------------------
module log_line_field_tokenizer_top #(
    parameter int STACK_DEPTH = lft_pkg::STACK_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_line_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_item_kind,
    output logic [7:0] m_char_out,
    output logic       m_line_done,
    output logic       m_stack_overflow,
    output logic       m_run_last
);
    import lft_pkg::*;

    logic     accept;
    logic     rec_push;
    lft_rec_t rec;
    lft_rec_t head;
    logic     q_full;
    logic     q_not_empty;
    logic     q_pop;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    lft_front #(.STACK_DEPTH(STACK_DEPTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .char_in   (s_char_in),
        .line_last (s_line_last),
        .rec_push  (rec_push),
        .rec       (rec)
    );

    lft_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_rec  (rec),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    lft_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (q_not_empty),
        .head             (head),
        .pop              (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_item_kind      (m_item_kind),
        .m_char_out       (m_char_out),
        .m_line_done      (m_line_done),
        .m_stack_overflow (m_stack_overflow),
        .m_run_last       (m_run_last)
    );

endmodule

FILE: hdl/lft_checker.sv
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Watches the top level's ports for result channel rules.
// ----------------------------------------------------------------------------
module lft_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_item_kind,
    input logic [7:0] m_char_out,
    input logic       m_line_done,
    input logic       m_stack_overflow,
    input logic       m_run_last
);
    import lft_pkg::*;

    // A stalled result beat holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item_kind) &&
        $stable(m_char_out) && $stable(m_line_done) && $stable(m_stack_overflow) &&
        $stable(m_run_last))
        else $error("result beat changed while stalled");

    a_byte_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item_kind == KIND_BYTE |-> !m_line_done)
        else $error("token byte flagged as line done");

    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item_kind == KIND_END |-> m_char_out == 8'h00)
        else $error("end marker carries a nonzero byte");

    // The line's final end marker is always the last result of its byte.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_done |-> m_run_last && m_item_kind == KIND_END)
        else $error("line done beat is not the closing end marker");

endmodule

bind log_line_field_tokenizer_top lft_checker u_lft_checker (.*);

FILE: tb/sv/log_line_field_tokenizer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Log line field tokenizer testbench
// Feeds directed and random log lines through the tokenizer with random
// idling on both channels. A behavioral tokenizer works out the expected
// result beats of every accepted byte, and each result beat is compared
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module log_line_field_tokenizer_top_test;

    import lft_pkg::*;

    localparam int NEST_STK  = 0;
    localparam int STRIP_STK = 1;
    localparam int TX_SIDE   = 0;
    localparam int RX_SIDE   = 1;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } line_byte_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic       done;
        logic       ovf;
        logic       run_last;
    } token_beat_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_in   = 8'h00;
    logic       s_line_last = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic       m_item_kind;
    logic [7:0] m_char_out;
    logic       m_line_done;
    logic       m_stack_overflow;
    logic       m_run_last;

    log_line_field_tokenizer_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_in        (s_char_in),
        .s_line_last      (s_line_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_item_kind      (m_item_kind),
        .m_char_out       (m_char_out),
        .m_line_done      (m_line_done),
        .m_stack_overflow (m_stack_overflow),
        .m_run_last       (m_run_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    line_byte_t  pending_bytes[$];
    token_beat_t expected_beats[$];
    token_beat_t step_beats[$];
    logic [7:0]  line_buf[$];
    line_byte_t  tx_next;
    int          bytes_queued = 0;
    int          failures     = 0;
    int          beats_seen   = 0;
    int          calm_left [2] = '{0, 0};
    int          tx_gap       = 0;
    int          rx_gap       = 0;
    int          choke_left   = 0;
    bit          choke_used   = 1'b0;
    logic        in_taken     = 1'b0;

    // Tokenizer state, as it stands after reset.
    logic [2:0] delim_stack [2][STACK_DEPTH_DEF];
    int         stack_fill [2] = '{0, 0};
    logic [7:0] held_char     = 8'h00;
    logic       held_ok       = 1'b0;
    logic       token_empty   = 1'b1;
    logic       prev_space    = 1'b1;
    logic       line_overflow = 1'b0;

    // ------------------------------------------------------------------
    // Expected behavior
    // ------------------------------------------------------------------
    task automatic push_delim(input int which, input logic [2:0] code);
        if (stack_fill[which] < STACK_DEPTH_DEF) begin
            delim_stack[which][stack_fill[which]] = code;
            stack_fill[which]++;
        end else begin
            line_overflow = 1'b1;
        end
    endtask

    task automatic add_beat(input logic kind, input logic [7:0] ch, input logic done);
        token_beat_t b;
        b.kind     = kind;
        b.ch       = ch;
        b.done     = done;
        b.ovf      = line_overflow;
        b.run_last = 1'b0;
        step_beats.insert(step_beats.size(), b);
    endtask

    task automatic tokenize_byte(input logic [7:0] raw, input logic last);
        logic [7:0]  c;
        logic [2:0]  code;
        logic [2:0]  top;
        logic [2:0]  strip_top;
        logic        has_top;
        logic        tok;
        logic        split;
        logic        drop;
        step_beats.delete();
        c = (raw == CH_TAB) ? CH_SPACE : raw;
        case (c)
            CH_LBRACK: code = CODE_LBRACK;
            CH_RBRACK: code = CODE_RBRACK;
            CH_LBRACE: code = CODE_LBRACE;
            CH_RBRACE: code = CODE_RBRACE;
            CH_DQUOTE: code = CODE_DQUOTE;
            CH_SQUOTE: code = CODE_SQUOTE;
            default:   code = CODE_NONE;
        endcase
        tok   = 1'b0;
        split = 1'b0;

        if (c == CH_SPACE && prev_space) begin
            split = last;
        end else begin
            prev_space = (c == CH_SPACE);
            has_top = stack_fill[NEST_STK] > 0;
            if (has_top) begin
                top = delim_stack[NEST_STK][stack_fill[NEST_STK] - 1];
            end else begin
                top = CODE_NONE;
            end
            if (code == CODE_LBRACK || code == CODE_LBRACE) begin
                push_delim(NEST_STK, code);
            end else if (code == CODE_DQUOTE || code == CODE_SQUOTE) begin
                if (has_top && top == code) begin
                    stack_fill[NEST_STK]--;
                end else begin
                    push_delim(NEST_STK, code);
                end
            end else if ((code == CODE_RBRACK && top == CODE_LBRACK) ||
                         (code == CODE_RBRACE && top == CODE_LBRACE)) begin
                stack_fill[NEST_STK]--;
            end
            if (c == CH_SPACE && stack_fill[NEST_STK] == 0) begin
                split = 1'b1;
            end else begin
                tok = 1'b1;
            end
            if (last) begin
                split = 1'b1;
            end
        end

        if (tok) begin
            // Delimiters opening a token are stripped and remembered.
            if (!held_ok && code != CODE_NONE) begin
                push_delim(STRIP_STK, code);
            end else begin
                if (held_ok) begin
                    add_beat(KIND_BYTE, held_char, 1'b0);
                end
                held_char = c;
                held_ok   = 1'b1;
            end
            token_empty = 1'b0;
        end

        if (split) begin
            if (held_ok) begin
                drop = 1'b0;
                if (stack_fill[STRIP_STK] > 0) begin
                    strip_top = delim_stack[STRIP_STK][stack_fill[STRIP_STK] - 1];
                    drop = (strip_top == CODE_LBRACK && held_char == CH_RBRACK) ||
                           (strip_top == CODE_LBRACE && held_char == CH_RBRACE) ||
                           (strip_top == CODE_DQUOTE && held_char == CH_DQUOTE) ||
                           (strip_top == CODE_SQUOTE && held_char == CH_SQUOTE);
                end
                if (drop) begin
                    stack_fill[STRIP_STK]--;
                end else begin
                    add_beat(KIND_BYTE, held_char, 1'b0);
                end
            end
            if (!token_empty || last) begin
                add_beat(KIND_END, 8'h00, last);
            end
            held_ok     = 1'b0;
            token_empty = 1'b1;
        end

        if (step_beats.size() > 0) begin
            step_beats[step_beats.size() - 1].run_last = 1'b1;
        end
        foreach (step_beats[k]) begin
            expected_beats.insert(expected_beats.size(), step_beats[k]);
        end

        if (last) begin
            stack_fill[NEST_STK]  = 0;
            stack_fill[STRIP_STK] = 0;
            line_overflow = 1'b0;
            prev_space    = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // ------------------------------------------------------------------
    // Line generation
    // ------------------------------------------------------------------
    function automatic int idle_len(input int side);
        int r;
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left[side] = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_delim();
        case ($urandom_range(0, 5))
            0:       return CH_LBRACK;
            1:       return CH_RBRACK;
            2:       return CH_LBRACE;
            3:       return CH_RBRACE;
            4:       return CH_DQUOTE;
            default: return CH_SQUOTE;
        endcase
    endfunction

    task automatic add_line_char(input logic [7:0] ch);
        line_buf.insert(line_buf.size(), ch);
    endtask

    task automatic queue_byte(input logic [7:0] ch, input logic last);
        line_byte_t b;
        b.ch   = ch;
        b.last = last;
        pending_bytes.insert(pending_bytes.size(), b);
        bytes_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            queue_byte(s[i], i == s.len() - 1);
        end
    endtask

    task automatic add_sep();
        int n;
        n = $urandom_range(1, 3);
        repeat (n) add_line_char(($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE);
    endtask

    task automatic add_word();
        int         n;
        logic [7:0] b;
        n = $urandom_range(1, 6);
        repeat (n) begin
            b = 8'($urandom_range(33, 126));
            if (b == CH_LBRACK || b == CH_RBRACK || b == CH_LBRACE ||
                b == CH_RBRACE || b == CH_DQUOTE || b == CH_SQUOTE) begin
                b = "x";
            end
            add_line_char(b);
        end
    endtask

    task automatic add_field(input int lvl);
        int         pick;
        int         n;
        logic [7:0] open_ch;
        logic [7:0] close_ch;
        pick = (lvl >= 3) ? 0 : $urandom_range(0, 6);
        if (pick < 3) begin
            add_word();
        end else begin
            case (pick)
                3: begin open_ch = CH_LBRACK; close_ch = CH_RBRACK; end
                4: begin open_ch = CH_LBRACE; close_ch = CH_RBRACE; end
                5: begin open_ch = CH_DQUOTE; close_ch = CH_DQUOTE; end
                default: begin open_ch = CH_SQUOTE; close_ch = CH_SQUOTE; end
            endcase
            // Sometimes a key=value field, where the value is the group.
            if ($urandom_range(0, 3) == 0) begin
                add_word();
                add_line_char("=");
            end
            add_line_char(open_ch);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                if (i > 0) add_sep();
                add_field(lvl + 1);
            end
            add_line_char(close_ch);
        end
    endtask

    task automatic build_fields();
        int n;
        if ($urandom_range(0, 2) == 0) add_sep();
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
            if (i > 0) add_sep();
            add_field(0);
        end
        if ($urandom_range(0, 4) == 0) add_sep();
    endtask

    task automatic add_random_line();
        int style;
        int n;
        int pos;
        line_buf.delete();
        style = $urandom_range(0, 99);
        if (style < 70) begin
            build_fields();
        end else if (style < 85) begin
            // Noise: raw bytes, heavy on spaces, tabs and delimiters.
            n = $urandom_range(1, 12);
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: add_line_char(8'($urandom_range(0, 255)));
                    4:          add_line_char(CH_SPACE);
                    5:          add_line_char(CH_TAB);
                    default:    add_line_char(rand_delim());
                endcase
            end
        end else if (style < 95) begin
            // A well-formed line with a few bytes lost or delimiters added.
            build_fields();
            n = $urandom_range(1, 3);
            repeat (n) begin
                pos = $urandom_range(0, line_buf.size() - 1);
                if (line_buf.size() > 1 && $urandom_range(0, 1) == 1) begin
                    line_buf.delete(pos);
                end else begin
                    line_buf.insert(pos, rand_delim());
                end
            end
        end else begin
            // Deep nesting, enough to run past the stack depth now and then.
            n = $urandom_range(12, 20);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0:       add_line_char(CH_LBRACK);
                    1:       add_line_char(CH_LBRACE);
                    2:       add_line_char(CH_DQUOTE);
                    default: add_line_char(CH_SQUOTE);
                endcase
            end
            add_word();
            n = $urandom_range(0, n);
            repeat (n) add_line_char(rand_delim());
        end
        foreach (line_buf[i]) begin
            queue_byte(line_buf[i], i == line_buf.size() - 1);
        end
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_valid || expected_beats.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver and monitor
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (tx_gap > 0) begin
                s_valid <= 1'b0;
                tx_gap--;
            end else if (pending_bytes.size() > 0) begin
                tx_next = pending_bytes.pop_front();
                s_valid     <= 1'b1;
                s_char_in   <= tx_next.ch;
                s_line_last <= tx_next.last;
                tx_gap = idle_len(TX_SIDE);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (choke_left > 0) begin
            m_ready <= 1'b0;
            choke_left--;
        end else if (!choke_used && beats_seen >= 80) begin
            // One long hold-off so the block fills up and stalls its input.
            choke_used = 1'b1;
            choke_left = 300;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_ready <= 1'b0;
            rx_gap--;
        end else begin
            m_ready <= 1'b1;
            rx_gap = idle_len(RX_SIDE);
        end
    end

    always @(posedge aclk) begin
        token_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: kind %0d char %0d",
                       m_item_kind, m_char_out);
                failures++;
            end else begin
                want = expected_beats.pop_front();
                check_field("item_kind", want.kind, m_item_kind);
                check_field("char_out", want.ch, m_char_out);
                check_field("line_done", want.done, m_line_done);
                check_field("stack_overflow", want.ovf, m_stack_overflow);
                check_field("run_last", want.run_last, m_run_last);
            end
        end
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) begin
            tokenize_byte(s_char_in, s_line_last);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // A line of one space, a stripped brace pair behind a tab, an unmatched
        // closer with a quoted group holding spaces, a token of quotes only
        // followed by the byte extremes, and a run of openers past the depth.
        queue_text(" ");
        queue_text("\t{x}");
        queue_text("]a\"b  c\"\t");
        queue_byte(CH_SQUOTE, 1'b0);
        queue_byte(CH_SQUOTE, 1'b0);
        queue_byte(CH_SPACE, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        for (int i = 0; i < STACK_DEPTH_DEF + 1; i++) begin
            queue_byte(CH_LBRACK, i == STACK_DEPTH_DEF);
        end
        wait_idle();

        while (bytes_queued < 260) add_random_line();
        wait_idle();
        while (bytes_queued < 450) add_random_line();
        wait_idle();

        repeat (20) @(posedge aclk);
        if (failures == 0) begin
            $display("log_line_field_tokenizer_top_test passed");
        end else begin
            $display("log_line_field_tokenizer_top_test failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("log_line_field_tokenizer_top_test failed");
        $finish;
    end

endmodule
